// ----- hdl/csem_pkg.sv -----
package csem_pkg;

    typedef enum logic [2:0] {
        EV_ENTERED  = 3'd0,
        EV_BLOCKED  = 3'd1,
        EV_EXITED   = 3'd2,
        EV_WOKEN    = 3'd3,
        EV_WAIT_FULL = 3'd4,
        EV_NO_HOLDER = 3'd5
    } t_event;

    localparam logic ACT_DOWN = 1'b0;
    localparam logic ACT_UP   = 1'b1;

    localparam int          RC_WIDTH = 5;
    localparam logic [4:0]  RC_RESET = 5'd9;
    localparam logic        REG_RESOURCE_COUNT = 1'b0;

endpackage

// ----- hdl/csem_ram.sv -----
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/counting_semaphore_with_wait_queue_core.sv -----
// output: the first result is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle while o_stall is low; a release that wakes a waiter
//   gives two results, the second once the first is taken, and holds off new requests meanwhile
// queue heads come from registered ram reads prefetched at the next head index
// reset: synchronous, active low; empties both queues, resource_count to 9
module counting_semaphore_with_wait_queue_core
    import csem_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_process_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_event_process,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int CMPW = (CW > RC_WIDTH) ? CW : RC_WIDTH;

    function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [SW-1:0] s;
        logic [SW-1:0] t;
        s = SW'(base) + SW'(offs);
        t = (s >= SW'(QUEUE_DEPTH)) ? (s - SW'(QUEUE_DEPTH)) : s;
        return t[AW-1:0];
    endfunction

    logic [RC_WIDTH-1:0] r_rc;
    logic [AW-1:0]       r_h_head, n_h_head, r_w_head, n_w_head;
    logic [CW-1:0]       r_h_fill, n_h_fill, r_w_fill, n_w_fill;

    logic                r_o_valid, n_o_valid, r_s_valid, n_s_valid;
    logic [2:0]          r_o_res, n_o_res;
    logic [ID_WIDTH-1:0] r_o_proc, n_o_proc, r_s_proc, n_s_proc;
    logic                r_o_last, n_o_last;

    logic                r_h_fwd_v, r_w_fwd_v;
    logic [ID_WIDTH-1:0] r_h_fwd_d, r_w_fwd_d;

    logic                h_we, w_we;
    logic [AW-1:0]       h_waddr, w_waddr;
    logic [ID_WIDTH-1:0] h_wdata, w_wdata;
    logic [ID_WIDTH-1:0] h_rdata, w_rdata, h_head_val, w_head_val;

    logic                in_acc, out_acc, cfg_wr, wake;
    logic [15:0]         pid_ext, proc_ext;
    logic [ID_WIDTH-1:0] pid;
    logic [CW-1:0]       h_fill_m1;

    csem_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_holder_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (n_h_head),
        .o_rdata (h_rdata)
    );

    csem_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_w_head),
        .o_rdata (w_rdata)
    );

    assign o_stall = r_s_valid || (r_o_valid && i_stall);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_o_valid && !i_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign pid_ext    = 16'(i_process_id);
    assign pid        = pid_ext[ID_WIDTH-1:0];
    assign h_head_val = r_h_fwd_v ? r_h_fwd_d : h_rdata;
    assign w_head_val = r_w_fwd_v ? r_w_fwd_d : w_rdata;
    assign h_fill_m1  = r_h_fill - CW'(1);

    always_comb begin
        n_h_head  = r_h_head;
        n_h_fill  = r_h_fill;
        n_w_head  = r_w_head;
        n_w_fill  = r_w_fill;
        h_we      = 1'b0;
        h_waddr   = wrap_idx(r_h_head, r_h_fill);
        h_wdata   = pid;
        w_we      = 1'b0;
        w_waddr   = wrap_idx(r_w_head, r_w_fill);
        w_wdata   = pid;
        wake      = 1'b0;
        n_o_valid = r_o_valid;
        n_o_res   = r_o_res;
        n_o_proc  = r_o_proc;
        n_o_last  = r_o_last;
        n_s_valid = r_s_valid;
        n_s_proc  = r_s_proc;

        if (out_acc) begin
            n_o_valid = r_s_valid;
            n_o_res   = EV_WOKEN;
            n_o_proc  = r_s_proc;
            n_o_last  = 1'b1;
            n_s_valid = 1'b0;
        end

        if (in_acc) begin
            n_o_valid = 1'b1;
            n_o_last  = 1'b1;
            n_o_proc  = pid;
            if (i_action == ACT_DOWN) begin
                if ((CMPW'(r_h_fill) < CMPW'(r_rc)) && (r_h_fill != CW'(QUEUE_DEPTH))) begin
                    h_we     = 1'b1;
                    n_h_fill = r_h_fill + CW'(1);
                    n_o_res  = EV_ENTERED;
                end else if (r_w_fill != CW'(QUEUE_DEPTH)) begin
                    w_we     = 1'b1;
                    n_w_fill = r_w_fill + CW'(1);
                    n_o_res  = EV_BLOCKED;
                end else begin
                    n_o_res  = EV_WAIT_FULL;
                end
            end else if (r_h_fill == '0) begin
                n_o_res  = EV_NO_HOLDER;
                n_o_proc = '0;
            end else begin
                wake     = (r_w_fill != '0) && (CMPW'(h_fill_m1) < CMPW'(r_rc));
                n_h_head = wrap_idx(r_h_head, CW'(1));
                n_h_fill = h_fill_m1;
                n_o_res  = EV_EXITED;
                n_o_proc = h_head_val;
                n_o_last = !wake;
                if (wake) begin
                    // woken waiter takes the freed slot at the tail
                    h_we      = 1'b1;
                    h_wdata   = w_head_val;
                    n_h_fill  = r_h_fill;
                    n_w_head  = wrap_idx(r_w_head, CW'(1));
                    n_w_fill  = r_w_fill - CW'(1);
                    n_s_valid = 1'b1;
                    n_s_proc  = w_head_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc      <= RC_RESET;
            r_h_head  <= '0;
            r_h_fill  <= '0;
            r_w_head  <= '0;
            r_w_fill  <= '0;
            r_o_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_h_fwd_v <= 1'b0;
            r_w_fwd_v <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == REG_RESOURCE_COUNT)) begin
                r_rc <= pwdata[RC_WIDTH-1:0];
            end
            r_h_head  <= n_h_head;
            r_h_fill  <= n_h_fill;
            r_w_head  <= n_w_head;
            r_w_fill  <= n_w_fill;
            r_o_valid <= n_o_valid;
            r_s_valid <= n_s_valid;
            // ram reads old data when written at the prefetched head
            r_h_fwd_v <= h_we && (h_waddr == n_h_head);
            r_w_fwd_v <= w_we && (w_waddr == n_w_head);
        end
        r_h_fwd_d <= h_wdata;
        r_w_fwd_d <= w_wdata;
        r_o_res   <= n_o_res;
        r_o_proc  <= n_o_proc;
        r_o_last  <= n_o_last;
        r_s_proc  <= n_s_proc;
    end

    assign proc_ext        = 16'(r_o_proc);
    assign o_valid         = r_o_valid;
    assign o_event_res     = r_o_res;
    assign o_event_process = proc_ext[7:0];
    assign o_last          = r_o_last;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_RESOURCE_COUNT) ? 32'(r_rc) : 32'd0;

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_o_valid)
        else $error("pending second result without a first");

    a_no_accept_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_s_valid)
        else $error("request taken while a second result waits");

    a_holder_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h_fill <= CW'(QUEUE_DEPTH))
        else $error("holder queue overfilled");

    a_waiter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_fill <= CW'(QUEUE_DEPTH))
        else $error("wait queue overfilled");

    a_wake_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && wake) |=> (r_h_fill == $past(r_h_fill)) && r_s_valid)
        else $error("wake did not refill the holder queue");

endmodule
